/* src/xcfr_pkg.sv */
// Package for the XOR-checked frame receiver.
// Holds frame marker bytes, beat payload types and the parser phase type.
// No dependencies; the receiver refers to it by scoped names, the sim files import it.
package xcfr_pkg;

    // Default index of the check byte; the frame is this plus three bytes long.
    localparam int PAYLOAD_END_INDEX_DEF = 29;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 6;

    // Frame marker bytes and the seed of the running check.
    localparam logic [BYTE_W-1:0] START_BYTE = 8'h02;
    localparam logic [BYTE_W-1:0] HDR1_BYTE  = 8'h3A;
    localparam logic [BYTE_W-1:0] HDR2_BYTE  = 8'h04;
    localparam logic [BYTE_W-1:0] TRL1_BYTE  = 8'h0F;
    localparam logic [BYTE_W-1:0] TRL2_BYTE  = 8'h04;
    localparam logic [BYTE_W-1:0] XOR_SEED   = 8'h04;

    // Parser phase; ST_DUMP reads the stored frame out.
    typedef enum logic [2:0] {
        ST_HUNT,
        ST_HDR1,
        ST_HDR2,
        ST_DATA,
        ST_CHECK,
        ST_TRL1,
        ST_TRL2,
        ST_DUMP
    } t_phase;

    // Input beat.
    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
    } t_rx_beat;

    // Output beat.
    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic [POS_W-1:0]  byte_position;
        logic              frame_last;
    } t_frame_beat;

endpackage

/* src/xcfr_stream_if.sv */
// Valid/ready stream interface used by both channels of the frame receiver.
// The payload type is a parameter; the beat types come from xcfr_pkg.
interface xcfr_stream_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/xcfr_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; the frame receiver uses it as its frame store.
module xcfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/xor_checked_frame_receiver.sv */
// Top level of the XOR-checked frame receiver: byte parser and frame readout.
// Depends on xcfr_pkg, xcfr_stream_if and xcfr_ram.
//
//   Channel   Dir  Payload                                  Handshake
//   i_rx      in   rx_byte                                  valid/ready
//   o_frame   out  frame_byte, byte_position, frame_last    valid/ready
//
// While parsing, one received byte is taken every cycle; frame bytes go to the store.
// On the final trailer byte the frame is read back out of the store, each byte going
// through a RAM read and then the output register, with one read in flight at a time;
// the receiver stops taking input after a good frame until its last read is issued.
// Reset is synchronous, active low, and clears the parser; the store is not
// cleared, since a frame rewrites every position before it is read.
// A stalled output holds the current beat and delays the next read.
module xor_checked_frame_receiver #(
    parameter int PAYLOAD_END_INDEX = xcfr_pkg::PAYLOAD_END_INDEX_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    xcfr_stream_if.sink   i_rx,
    xcfr_stream_if.source o_frame
);

    localparam int FRAME_LEN = PAYLOAD_END_INDEX + 3;
    localparam int ADDR_W    = $clog2(FRAME_LEN);
    localparam logic [xcfr_pkg::POS_W-1:0] LAST_POS    = xcfr_pkg::POS_W'(FRAME_LEN - 1);
    localparam logic [xcfr_pkg::POS_W-1:0] PAYLOAD_END =
        xcfr_pkg::POS_W'(PAYLOAD_END_INDEX);

    xcfr_pkg::t_phase r_phase, n_phase;
    logic [xcfr_pkg::POS_W-1:0]  r_fill, n_fill;
    logic [xcfr_pkg::BYTE_W-1:0] r_xor, n_xor;

    logic [xcfr_pkg::POS_W-1:0]  r_rd_pos;
    logic [xcfr_pkg::POS_W-1:0]  r_pend_pos;
    logic                        r_rd_pend;
    logic                        r_out_valid;
    xcfr_pkg::t_frame_beat       r_out;

    logic                        w_rx_fire;
    logic [xcfr_pkg::BYTE_W-1:0] w_b;
    logic [xcfr_pkg::POS_W-1:0]  w_fill_inc;
    logic                        w_wr_en;
    logic [ADDR_W-1:0]           w_wr_addr;
    logic                        w_rd_issue;
    logic [xcfr_pkg::BYTE_W-1:0] w_rd_data;

    // Input side is open whenever the stored frame is not being read out.
    assign i_rx.ready = (r_phase != xcfr_pkg::ST_DUMP);
    assign w_rx_fire  = i_rx.valid && i_rx.ready;
    assign w_b        = i_rx.data.rx_byte;
    assign w_fill_inc = r_fill + 1'b1;

    // A read is issued when none is in flight and the output register will be free.
    assign w_rd_issue = (r_phase == xcfr_pkg::ST_DUMP) && !r_rd_pend &&
                        (!r_out_valid || o_frame.ready);

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            xcfr_pkg::ST_HUNT: begin
                if (w_rx_fire && w_b == xcfr_pkg::START_BYTE) begin
                    n_phase = xcfr_pkg::ST_HDR1;
                end
            end
            xcfr_pkg::ST_HDR1: begin
                if (w_rx_fire) begin
                    if (w_b == xcfr_pkg::START_BYTE) begin
                        n_phase = xcfr_pkg::ST_HDR1;
                    end else if (w_b == xcfr_pkg::HDR1_BYTE) begin
                        n_phase = xcfr_pkg::ST_HDR2;
                    end else begin
                        n_phase = xcfr_pkg::ST_HUNT;
                    end
                end
            end
            xcfr_pkg::ST_HDR2: begin
                if (w_rx_fire) begin
                    if (w_b == xcfr_pkg::START_BYTE) begin
                        n_phase = xcfr_pkg::ST_HDR1;
                    end else if (w_b == xcfr_pkg::HDR2_BYTE) begin
                        n_phase = xcfr_pkg::ST_DATA;
                    end else begin
                        n_phase = xcfr_pkg::ST_HUNT;
                    end
                end
            end
            xcfr_pkg::ST_DATA: begin
                if (w_rx_fire && w_fill_inc == PAYLOAD_END) begin
                    n_phase = xcfr_pkg::ST_CHECK;
                end
            end
            xcfr_pkg::ST_CHECK: begin
                if (w_rx_fire) begin
                    n_phase = (w_b == r_xor) ? xcfr_pkg::ST_TRL1 : xcfr_pkg::ST_HUNT;
                end
            end
            xcfr_pkg::ST_TRL1: begin
                if (w_rx_fire) begin
                    n_phase = (w_b == xcfr_pkg::TRL1_BYTE) ? xcfr_pkg::ST_TRL2
                                                           : xcfr_pkg::ST_HUNT;
                end
            end
            xcfr_pkg::ST_TRL2: begin
                if (w_rx_fire) begin
                    n_phase = (w_b == xcfr_pkg::TRL2_BYTE) ? xcfr_pkg::ST_DUMP
                                                           : xcfr_pkg::ST_HUNT;
                end
            end
            xcfr_pkg::ST_DUMP: begin
                if (w_rd_issue && r_rd_pos == LAST_POS) begin
                    n_phase = xcfr_pkg::ST_HUNT;
                end
            end
            default: n_phase = xcfr_pkg::ST_HUNT;
        endcase
    end

    // Store writes, fill position and running check for each phase.
    always_comb begin
        n_fill    = r_fill;
        n_xor     = r_xor;
        w_wr_en   = 1'b0;
        w_wr_addr = r_fill[ADDR_W-1:0];
        unique case (r_phase) inside
            xcfr_pkg::ST_HUNT: begin
                if (w_rx_fire) begin
                    n_fill = '0;
                    if (w_b == xcfr_pkg::START_BYTE) begin
                        n_xor     = '0;
                        w_wr_en   = 1'b1;
                        w_wr_addr = '0;
                        n_fill    = xcfr_pkg::POS_W'(1);
                    end
                end
            end
            xcfr_pkg::ST_HDR1, xcfr_pkg::ST_HDR2: begin
                if (w_rx_fire) begin
                    if (w_b == xcfr_pkg::START_BYTE) begin
                        w_wr_en   = 1'b1;
                        w_wr_addr = '0;
                        n_fill    = xcfr_pkg::POS_W'(1);
                    end else if (r_phase == xcfr_pkg::ST_HDR1 &&
                                 w_b == xcfr_pkg::HDR1_BYTE) begin
                        w_wr_en = 1'b1;
                        n_fill  = w_fill_inc;
                    end else if (r_phase == xcfr_pkg::ST_HDR2 &&
                                 w_b == xcfr_pkg::HDR2_BYTE) begin
                        w_wr_en = 1'b1;
                        n_fill  = w_fill_inc;
                        n_xor   = xcfr_pkg::XOR_SEED;
                    end
                end
            end
            xcfr_pkg::ST_DATA: begin
                if (w_rx_fire) begin
                    w_wr_en = 1'b1;
                    n_fill  = w_fill_inc;
                    n_xor   = r_xor ^ w_b;
                end
            end
            xcfr_pkg::ST_CHECK: begin
                if (w_rx_fire && w_b == r_xor) begin
                    w_wr_en = 1'b1;
                    n_fill  = w_fill_inc;
                end
            end
            xcfr_pkg::ST_TRL1: begin
                if (w_rx_fire && w_b == xcfr_pkg::TRL1_BYTE) begin
                    w_wr_en = 1'b1;
                    n_fill  = w_fill_inc;
                end
            end
            xcfr_pkg::ST_TRL2: begin
                // The final byte is stored but the fill position stays put.
                if (w_rx_fire && w_b == xcfr_pkg::TRL2_BYTE) begin
                    w_wr_en = 1'b1;
                end
            end
            xcfr_pkg::ST_DUMP: begin
                n_fill = r_fill;
            end
            default: n_fill = '0;
        endcase
    end

    // Parser registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= xcfr_pkg::ST_HUNT;
            r_fill  <= '0;
            r_xor   <= '0;
        end else begin
            r_phase <= n_phase;
            r_fill  <= n_fill;
            r_xor   <= n_xor;
        end
    end

    // Frame store.
    xcfr_ram #(
        .WIDTH (xcfr_pkg::BYTE_W),
        .DEPTH (FRAME_LEN)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_b),
        .i_rd_en   (w_rd_issue),
        .i_rd_addr (r_rd_pos[ADDR_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    // Readout sequencing: read position and in-flight read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pos  <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= w_rd_issue;
            if (w_rd_issue) begin
                r_rd_pos <= (r_rd_pos == LAST_POS) ? '0 : r_rd_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_issue) begin
            r_pend_pos <= r_rd_pos;
        end
    end

    // Output register: loaded from the read data, cleared when the beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_rd_pend) begin
            r_out_valid <= 1'b1;
        end else if (o_frame.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_pend) begin
            r_out.frame_byte    <= w_rd_data;
            r_out.byte_position <= r_pend_pos;
            r_out.frame_last    <= (r_pend_pos == LAST_POS);
        end
    end

    assign o_frame.valid = r_out_valid;
    assign o_frame.data  = r_out;

`ifndef SYNTH
    // A read in flight always lands in the output register on the next edge.
    a_read_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |=> o_frame.valid)
        else $error("read data did not reach the output register");

    // The last marker only appears on the final frame position.
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_frame.valid && o_frame.data.frame_last) |->
            (o_frame.data.byte_position == LAST_POS))
        else $error("frame_last on a wrong position");

    // The store is never written while a frame is being read out.
    a_no_write_in_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r_phase != xcfr_pkg::ST_DUMP))
        else $error("store written during readout");

    // A read is never issued while the output register holds a stalled beat.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_frame.valid && !o_frame.ready) |-> !w_rd_issue)
        else $error("read issued over a stalled output beat");
`endif

endmodule

/* sim/xcfr_frame_checker.sv */
`timescale 1ns / 1ps
// Checker for the XOR-checked frame receiver: watches both channels, predicts the frames.
// Depends on xcfr_pkg for the marker bytes, the phase type and the beat types.
module xcfr_frame_checker #(
    parameter int PAYLOAD_END_INDEX = xcfr_pkg::PAYLOAD_END_INDEX_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_rx_valid,
    input  logic                   i_rx_ready,
    input  xcfr_pkg::t_rx_beat     i_rx_beat,
    input  logic                   i_frame_valid,
    input  logic                   i_frame_ready,
    input  xcfr_pkg::t_frame_beat  i_frame_beat,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_beats_due_total,
    output int                     o_beats_checked
);
    import xcfr_pkg::*;

    localparam int FRAME_LEN = PAYLOAD_END_INDEX + 3;

    // Shadow copy of the parser state.
    t_phase            phase;
    logic [POS_W-1:0]  fill;
    logic [BYTE_W-1:0] check_acc;
    logic [BYTE_W-1:0] frame_copy [64];

    // Frame beats predicted but not yet seen on the output channel.
    t_frame_beat beats_due [$];
    int          mismatches = 0;
    int          due_total  = 0;
    int          checked    = 0;

    task automatic keep_byte(input logic [BYTE_W-1:0] b);
        frame_copy[fill] = b;
        fill = fill + 1'b1;
    endtask

    task automatic open_header();
        fill = '0;
        keep_byte(START_BYTE);
        phase = ST_HDR1;
    endtask

    // Advance the shadow parser by one received byte; queue the frame on a good trailer.
    task automatic parse_rx_byte(input logic [BYTE_W-1:0] b);
        t_frame_beat beat;
        case (phase)
            ST_HUNT: begin
                fill = '0;
                if (b == START_BYTE) begin
                    check_acc = '0;
                    open_header();
                end
            end
            ST_HDR1: begin
                if (b == START_BYTE) begin
                    open_header();
                end else if (b == HDR1_BYTE) begin
                    keep_byte(b);
                    phase = ST_HDR2;
                end else begin
                    phase = ST_HUNT;
                end
            end
            ST_HDR2: begin
                if (b == START_BYTE) begin
                    open_header();
                end else if (b == HDR2_BYTE) begin
                    check_acc = XOR_SEED;
                    keep_byte(b);
                    phase = ST_DATA;
                end else begin
                    phase = ST_HUNT;
                end
            end
            ST_DATA: begin
                keep_byte(b);
                check_acc = check_acc ^ b;
                if (int'(fill) == PAYLOAD_END_INDEX) begin
                    phase = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (b == check_acc) begin
                    keep_byte(b);
                    phase = ST_TRL1;
                end else begin
                    phase = ST_HUNT;
                end
            end
            ST_TRL1: begin
                if (b == TRL1_BYTE) begin
                    keep_byte(b);
                    phase = ST_TRL2;
                end else begin
                    phase = ST_HUNT;
                end
            end
            ST_TRL2: begin
                if (b == TRL2_BYTE) begin
                    frame_copy[fill] = b;
                    for (int k = 0; k < FRAME_LEN; k++) begin
                        beat.frame_byte    = frame_copy[POS_W'(k)];
                        beat.byte_position = POS_W'(k);
                        beat.frame_last    = (k == FRAME_LEN - 1);
                        beats_due.push_back(beat);
                        due_total++;
                    end
                end
                phase = ST_HUNT;
            end
            default: begin
                fill = '0;
                phase = ST_HUNT;
            end
        endcase
    endtask

    // Compare one output beat with the oldest prediction.
    task automatic check_frame_beat(input t_frame_beat got);
        t_frame_beat want;
        checked++;
        if (beats_due.size() == 0) begin
            if (mismatches < 10) begin
                $display("[%0t] unexpected frame beat: byte %h pos %0d last %b",
                         $realtime, got.frame_byte, got.byte_position, got.frame_last);
            end
            mismatches++;
        end else begin
            want = beats_due.pop_front();
            if (want.frame_byte !== got.frame_byte
                    || want.byte_position !== got.byte_position
                    || want.frame_last !== got.frame_last) begin
                if (mismatches < 10) begin
                    $display("[%0t] frame beat mismatch: expected byte %h pos %0d last %b,",
                             $realtime, want.frame_byte, want.byte_position, want.frame_last);
                    $display("        got byte %h pos %0d last %b",
                             got.frame_byte, got.byte_position, got.frame_last);
                end
                mismatches++;
            end
        end
    endtask

    // Output beats are checked before the input beat of the same edge is parsed,
    // so a beat can never be matched against a prediction made at its own edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase     = ST_HUNT;
            fill      = '0;
            check_acc = '0;
            beats_due.delete();
        end else begin
            if (i_frame_valid && i_frame_ready) begin
                check_frame_beat(i_frame_beat);
            end
            if (i_rx_valid && i_rx_ready) begin
                parse_rx_byte(i_rx_beat.rx_byte);
            end
        end
        o_fail_count      <= mismatches;
        o_pending         <= beats_due.size();
        o_beats_due_total <= due_total;
        o_beats_checked   <= checked;
    end

endmodule

/* sim/xor_checked_frame_receiver_tb.sv */
`timescale 1ns / 1ps
// Top of the frame receiver testbench: clock, reset, byte stimulus, output stalls, verdict.
// Depends on xcfr_pkg, xcfr_stream_if, the receiver itself and xcfr_frame_checker.
module xor_checked_frame_receiver_tb;
    import xcfr_pkg::*;

    localparam int PAYLOAD_END = PAYLOAD_END_INDEX_DEF;
    localparam int FRAME_LEN   = PAYLOAD_END + 3;
    localparam int HOLD_CYCLES = 400;

    // How a generated frame is spoiled, if at all.
    typedef enum int {
        FLAW_NONE,
        FLAW_RESTART_HDR1,
        FLAW_RESTART_HDR2,
        FLAW_HDR1,
        FLAW_HDR2,
        FLAW_SHORT,
        FLAW_CHECK,
        FLAW_TRL1,
        FLAW_TRL2
    } t_flaw;

    // Output stall patterns.
    typedef enum int {
        STALL_NONE,
        STALL_PERIODIC,
        STALL_COIN,
        STALL_HEAVY
    } t_stall_mode;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    xcfr_stream_if #(.t_data(t_rx_beat))    rx_if ();
    xcfr_stream_if #(.t_data(t_frame_beat)) frame_if ();

    int fail_count;
    int pending;
    int beats_due_total;
    int beats_checked;

    int burst_left    = 0;
    int sent_bytes    = 0;
    int hold_requests = 0;

    xor_checked_frame_receiver #(
        .PAYLOAD_END_INDEX(PAYLOAD_END)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_rx    (rx_if),
        .o_frame (frame_if)
    );

    xcfr_frame_checker #(
        .PAYLOAD_END_INDEX(PAYLOAD_END)
    ) u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_rx_valid        (rx_if.valid),
        .i_rx_ready        (rx_if.ready),
        .i_rx_beat         (rx_if.data),
        .i_frame_valid     (frame_if.valid),
        .i_frame_ready     (frame_if.ready),
        .i_frame_beat      (frame_if.data),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_beats_due_total (beats_due_total),
        .o_beats_checked   (beats_checked)
    );

    always #2 clk = ~clk;

    // Offer one byte, opening a new burst after a random gap when the last one ran out.
    task automatic drive_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                rx_if.valid <= 1'b0;
                rx_if.data  <= BYTE_W'($urandom_range(0, 255));
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        rx_if.valid <= 1'b1;
        rx_if.data  <= b;
        do @(posedge clk); while (!rx_if.ready);
        sent_bytes++;
    endtask

    // Stop offering until every predicted beat has come out.
    task automatic wait_drained();
        rx_if.valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [BYTE_W-1:0] payload_byte(input bit extreme);
        if (!extreme) begin
            return BYTE_W'($urandom_range(0, 255));
        end
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            2: return START_BYTE;
            3: return HDR1_BYTE;
            4: return TRL1_BYTE;
            default: return 8'h01 << $urandom_range(0, 7);
        endcase
    endfunction

    // A byte other than the expected one; a start byte only where that is allowed.
    function automatic logic [BYTE_W-1:0] off_byte(input logic [BYTE_W-1:0] good,
                                                  input bit allow_start, input bit want_start);
        logic [BYTE_W-1:0] b;
        if (allow_start && (want_start || $urandom_range(0, 3) == 0) && good != START_BYTE) begin
            return START_BYTE;
        end
        do begin
            b = BYTE_W'($urandom_range(0, 255));
        end while (b == good || b == START_BYTE);
        return b;
    endfunction

    // Send one frame, spoiled as asked; returns the number of bytes offered.
    task automatic send_frame(input t_flaw flaw, input bit extreme, input bit start_as_flaw,
                              output int count);
        logic [BYTE_W-1:0] acc;
        int                cut;
        count = 0;
        drive_byte(START_BYTE);
        count++;
        if (flaw == FLAW_RESTART_HDR1) begin
            drive_byte(START_BYTE);
            count++;
        end
        if (flaw == FLAW_HDR1) begin
            drive_byte(off_byte(HDR1_BYTE, 1'b0, 1'b0));
            count++;
            return;
        end
        drive_byte(HDR1_BYTE);
        count++;
        if (flaw == FLAW_RESTART_HDR2) begin
            drive_byte(START_BYTE);
            drive_byte(HDR1_BYTE);
            count += 2;
        end
        if (flaw == FLAW_HDR2) begin
            drive_byte(off_byte(HDR2_BYTE, 1'b0, 1'b0));
            count++;
            return;
        end
        drive_byte(HDR2_BYTE);
        count++;

        // Payload; a short frame stops early and lets the next bytes run into it.
        acc = XOR_SEED;
        cut = (flaw == FLAW_SHORT) ? $urandom_range(0, PAYLOAD_END - 4) : PAYLOAD_END - 3;
        for (int k = 0; k < cut; k++) begin
            logic [BYTE_W-1:0] b;
            b = payload_byte(extreme);
            acc = acc ^ b;
            drive_byte(b);
            count++;
        end
        if (flaw == FLAW_SHORT) begin
            return;
        end

        drive_byte((flaw == FLAW_CHECK) ? off_byte(acc, 1'b1, start_as_flaw) : acc);
        count++;
        if (flaw == FLAW_CHECK) begin
            return;
        end
        drive_byte((flaw == FLAW_TRL1) ? off_byte(TRL1_BYTE, 1'b1, start_as_flaw) : TRL1_BYTE);
        count++;
        if (flaw == FLAW_TRL1) begin
            return;
        end
        drive_byte((flaw == FLAW_TRL2) ? off_byte(TRL2_BYTE, 1'b1, start_as_flaw) : TRL2_BYTE);
        count++;
    endtask

    // Output side: a changing stall pattern, plus a long hold-off whenever one is requested.
    initial begin
        t_stall_mode mode;
        int          mode_left;
        int          hold_left;
        int          hold_served;
        int          tick;
        mode_left   = 0;
        hold_left   = 0;
        hold_served = 0;
        tick        = 0;
        mode        = STALL_NONE;
        frame_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            tick++;
            if (hold_left > 0) begin
                hold_left--;
                frame_if.ready <= 1'b0;
            end else if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = HOLD_CYCLES - 1;
                frame_if.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_stall_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 200);
                end
                mode_left--;
                case (mode)
                    STALL_NONE:     frame_if.ready <= 1'b1;
                    STALL_PERIODIC: frame_if.ready <= (tick % 5) != 2;
                    STALL_COIN:     frame_if.ready <= 1'($urandom_range(0, 1));
                    default:        frame_if.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        int    n;
        int    pick;
        t_flaw flaw;
        rx_if.valid = 1'b0;
        rx_if.data  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: bytes the hunter ignores, then the main ways a frame can pass or fail.
        drive_byte(8'h00);
        drive_byte(8'hFF);
        drive_byte(HDR1_BYTE);
        send_frame(FLAW_RESTART_HDR2, 1'b1, 1'b0, n);
        send_frame(FLAW_HDR1, 1'b0, 1'b0, n);
        send_frame(FLAW_HDR2, 1'b0, 1'b0, n);
        // A start byte in the check slot is dropped, not taken as a new header.
        send_frame(FLAW_CHECK, 1'b0, 1'b1, n);
        drive_byte(HDR1_BYTE);
        drive_byte(HDR2_BYTE);
        send_frame(FLAW_TRL1, 1'b0, 1'b1, n);
        drive_byte(HDR1_BYTE);
        wait_drained();

        // Long output hold-off while bytes keep coming, so the input backs up.
        hold_requests++;
        send_frame(FLAW_RESTART_HDR1, 1'b0, 1'b0, n);
        drive_byte(8'h00);
        wait_drained();

        // Random: mostly good frames with random content, some spoiled frames and noise.
        while (sent_bytes < 160) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                send_frame(FLAW_NONE, $urandom_range(0, 3) == 0, 1'b0, n);
            end else if (pick < 88) begin
                flaw = t_flaw'($urandom_range(int'(FLAW_RESTART_HDR1), int'(FLAW_TRL2)));
                send_frame(flaw, $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)), n);
            end else if (pick < 96) begin
                repeat ($urandom_range(1, 6)) drive_byte(payload_byte(1'($urandom_range(0, 1))));
            end else if (pick < 98) begin
                hold_requests++;
            end else begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (2 * FRAME_LEN + 16) @(posedge clk);
        $display("Summary: %0d bytes received, %0d frame beats checked against %0d predicted.",
                 sent_bytes, beats_checked, beats_due_total);
        $display("Covered header restarts, header/check/trailer faults and output hold-offs.");
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2_000_000;
        $display("Timeout: %0d beats still expected.", pending);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* files.f */
src/xcfr_pkg.sv
src/xcfr_stream_if.sv
src/xcfr_ram.sv
src/xor_checked_frame_receiver.sv
sim/xcfr_frame_checker.sv
sim/xor_checked_frame_receiver_tb.sv
